### sv/tlfhp_pkg.sv
// Shared types and constants for the two-level free handle pool.
// No dependencies.
package tlfhp_pkg;
  typedef enum logic [2:0] {
    ST_LOCAL_HIT = 3'd0,
    ST_REFILL    = 3'd1,
    ST_FRESH     = 3'd2,
    ST_OOM       = 3'd3,
    ST_FREED     = 3'd4,
    ST_SPILLED   = 3'd5,
    ST_NULL      = 3'd6
  } status_t;

  localparam logic [1:0] CFG_BATCH      = 2'd0;
  localparam logic [1:0] CFG_LOCAL_LIM  = 2'd1;
  localparam logic [1:0] CFG_GLIM_EN    = 2'd2;
  localparam logic [1:0] CFG_GLOBAL_LIM = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CNT_W      = 11;

  // batch moves never cross a chunk of this many entries (power of two)
  localparam int CHUNK_WORDS = 16;
endpackage

### sv/two_level_free_handle_pool_core.sv
// Top level of the two-level free handle pool: sequencer, counters and stacks.
// Depends on tlfhp_pkg and tlfhp_ram.
//
// Usage: pulse start while busy is low; write configuration only while busy is
// low. A null free or out of memory goes straight to the result, a plain free
// pushes its handle, a local hit pops one, a fresh batch mints handles first.
// A refill or spill moves handles in chunk-bounded runs, one handle at a time
// through the read port of one stack and the write port of the other: a setup
// step per run, a read and a write step per handle, a closing step, a further
// step when handles are dropped on a full global pool; a spill ends with a trim
// step. The result is strobed by out_valid in the first cycle busy is low, and
// a new request can be accepted in that same cycle; the receiver cannot stall.
// No clearing pass after reset.
module two_level_free_handle_pool_core #(
  parameter int LOCAL_DEPTH  = 128,
  parameter int GLOBAL_DEPTH = 1024,
  parameter int HANDLE_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_operation,
  input  logic [15:0]                         in_handle_in,
  output logic                                out_valid,
  output logic [15:0]                         out_handle_out,
  output logic [2:0]                          out_status,
  output logic [7:0]                          out_local_count,
  output logic [10:0]                         out_global_count,
  output logic [10:0]                         out_released_count,
  input  logic                                cfg_we,
  input  logic [tlfhp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlfhp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  localparam int LA_W = $clog2(LOCAL_DEPTH);
  localparam int GA_W = $clog2(GLOBAL_DEPTH);
  localparam int LS_W = $clog2(LOCAL_DEPTH + 1);
  localparam int GS_W = $clog2(GLOBAL_DEPTH + 1);
  localparam int FH_W = HANDLE_BITS + 1;
  localparam int PT_W = (GS_W > LS_W) ? GS_W : LS_W;
  localparam int CHUNK = tlfhp_pkg::CHUNK_WORDS;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_RUN, S_MOVE_RD, S_MOVE_WR, S_FRESH, S_POP_RD, S_POP_WAIT,
    S_PUSH, S_TRIM, S_DONE
  } state_t;

  state_t state_r;
  logic [7:0]  batch_r, llim_r;
  logic        glen_r;
  logic [10:0] glim_r;
  logic [LS_W-1:0] lsize_r;
  logic [GS_W-1:0] gsize_r;
  logic [FH_W-1:0] fresh_r;
  logic            op_r;
  logic [HANDLE_BITS-1:0] hin_r;
  logic [LS_W-1:0] cnt_r;
  logic [LS_W-1:0] run_r;
  logic [PT_W-1:0] ptr_r;
  logic            dir_r;
  logic            spilled_r, second_r;
  logic [10:0]     rel_r;
  logic [15:0]     hout_r;
  tlfhp_pkg::status_t st_r;

  // effective batch and limit
  logic [LS_W-1:0] eff_b, eff_lim;
  always_comb begin
    if (batch_r == 8'd0) eff_b = LS_W'(1);
    else if (32'(batch_r) > LOCAL_DEPTH) eff_b = LS_W'(LOCAL_DEPTH);
    else eff_b = LS_W'(batch_r);
    if (32'(llim_r) > LOCAL_DEPTH) eff_lim = LS_W'(LOCAL_DEPTH);
    else eff_lim = LS_W'(llim_r);
  end

  // memories
  logic l_we, g_we;
  logic [LA_W-1:0] l_wa, l_ra;
  logic [GA_W-1:0] g_wa, g_ra;
  logic [HANDLE_BITS-1:0] l_wd, l_rd, g_wd, g_rd;

  tlfhp_ram #(.DEPTH(LOCAL_DEPTH), .WIDTH(HANDLE_BITS)) u_local (
    .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
  tlfhp_ram #(.DEPTH(GLOBAL_DEPTH), .WIDTH(HANDLE_BITS)) u_global (
    .clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));

  logic [LS_W-1:0] lsm1, lsp1, spl_cnt;
  logic [GS_W-1:0] gsm1;
  assign lsm1 = lsize_r - LS_W'(1);
  assign lsp1 = lsize_r + LS_W'(1);
  assign gsm1 = gsize_r - GS_W'(1);
  // a spill after a push moves at most the handles present
  assign spl_cnt = (eff_b < lsp1) ? eff_b : lsp1;

  // length of the next run: topmost source run, bounded by both chunks and room
  int run_src, run_dst, run_cap, run_f, run_t, run_len;
  logic [LS_W-1:0] run_n;
  always_comb begin
    run_src = dir_r ? 32'(lsize_r) : 32'(gsize_r);
    run_dst = dir_r ? 32'(gsize_r) : 32'(lsize_r);
    run_cap = dir_r ? GLOBAL_DEPTH : LOCAL_DEPTH;
    run_f = run_src - ((run_src - 1) / CHUNK) * CHUNK;
    run_t = CHUNK - (run_dst % CHUNK);
    run_len = 32'(cnt_r);
    if (run_f < run_len) run_len = run_f;
    if (run_t < run_len) run_len = run_t;
    if (run_cap - run_dst < run_len) run_len = run_cap - run_dst;
    run_n = LS_W'(run_len);
  end

  // memory port control
  always_comb begin
    l_we = 1'b0; g_we = 1'b0;
    l_wa = lsize_r[LA_W-1:0];
    l_wd = hin_r;
    l_ra = lsm1[LA_W-1:0];
    g_wa = gsize_r[GA_W-1:0];
    g_wd = l_rd;
    g_ra = gsm1[GA_W-1:0];
    unique case (state_r)
      S_MOVE_RD: begin
        l_ra = ptr_r[LA_W-1:0];
        g_ra = ptr_r[GA_W-1:0];
      end
      S_MOVE_WR: begin
        if (dir_r) begin
          g_we = 1'b1;
        end else begin
          l_we = 1'b1;
          l_wd = g_rd;
        end
      end
      S_FRESH: begin
        l_we = 1'b1;
        l_wd = fresh_r[HANDLE_BITS-1:0];
      end
      S_PUSH: l_we = 1'b1;
      default: ;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  logic [HANDLE_BITS-1:0] hmask;
  assign hmask = in_handle_in[HANDLE_BITS-1:0];

  tlfhp_pkg::status_t st_out;
  assign st_out = (op_r && !spilled_r && hin_r != '0) ? tlfhp_pkg::ST_FREED : st_r;

  // sequencer, counters and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      batch_r <= 8'd64; llim_r <= 8'd128; glen_r <= 1'b0; glim_r <= 11'd1024;
      lsize_r <= '0; gsize_r <= '0; fresh_r <= FH_W'(1);
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          tlfhp_pkg::CFG_BATCH:      batch_r <= cfg_data[7:0];
          tlfhp_pkg::CFG_LOCAL_LIM:  llim_r <= cfg_data[7:0];
          tlfhp_pkg::CFG_GLIM_EN:    glen_r <= cfg_data[0];
          tlfhp_pkg::CFG_GLOBAL_LIM: glim_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r <= in_operation; hin_r <= hmask;
            rel_r <= '0; spilled_r <= 1'b0; second_r <= 1'b0; hout_r <= '0;
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!op_r) begin
            if (lsize_r != '0) begin
              st_r <= tlfhp_pkg::ST_LOCAL_HIT; state_r <= S_POP_RD;
            end else if (32'(gsize_r) >= 32'(eff_b)) begin
              st_r <= tlfhp_pkg::ST_REFILL; cnt_r <= eff_b; dir_r <= 1'b0;
              state_r <= S_RUN;
            end else if (fresh_r[HANDLE_BITS]) begin
              st_r <= tlfhp_pkg::ST_OOM; state_r <= S_DONE;
            end else begin
              st_r <= tlfhp_pkg::ST_FRESH; cnt_r <= eff_b; state_r <= S_FRESH;
            end
          end else if (hin_r == '0) begin
            st_r <= tlfhp_pkg::ST_NULL; state_r <= S_DONE;
          end else if (32'(lsize_r) >= LOCAL_DEPTH) begin
            spilled_r <= 1'b1; cnt_r <= eff_b; dir_r <= 1'b1; state_r <= S_RUN;
          end else begin
            state_r <= S_PUSH;
          end
        end
        // set up the next run, drop what no longer fits, or finish the move
        S_RUN: begin
          if (cnt_r == '0) begin
            if (!dir_r) state_r <= S_POP_RD;
            else state_r <= second_r ? S_TRIM : S_PUSH;
          end else if (run_n == '0) begin
            lsize_r <= lsize_r - cnt_r;
            if (32'(rel_r) + 32'(cnt_r) > 2047) rel_r <= '1;
            else rel_r <= 11'(32'(rel_r) + 32'(cnt_r));
            cnt_r <= '0;
          end else begin
            if (dir_r) lsize_r <= lsize_r - run_n;
            else gsize_r <= gsize_r - GS_W'(run_n);
            ptr_r <= PT_W'(run_src - run_len);
            run_r <= run_n;
            state_r <= S_MOVE_RD;
          end
        end
        S_MOVE_RD: state_r <= S_MOVE_WR;
        S_MOVE_WR: begin
          if (dir_r) gsize_r <= gsize_r + GS_W'(1);
          else lsize_r <= lsize_r + LS_W'(1);
          ptr_r <= ptr_r + PT_W'(1);
          run_r <= run_r - LS_W'(1);
          cnt_r <= cnt_r - LS_W'(1);
          state_r <= (run_r == LS_W'(1)) ? S_RUN : S_MOVE_RD;
        end
        S_FRESH: begin
          lsize_r <= lsize_r + LS_W'(1); fresh_r <= fresh_r + FH_W'(1);
          cnt_r <= cnt_r - LS_W'(1);
          if (cnt_r == LS_W'(1) || fresh_r[HANDLE_BITS-1:0] == '1) state_r <= S_POP_RD;
        end
        S_POP_RD: state_r <= S_POP_WAIT;
        S_POP_WAIT: begin
          hout_r <= 16'(l_rd); lsize_r <= lsm1; state_r <= S_DONE;
        end
        S_PUSH: begin
          lsize_r <= lsp1;
          second_r <= 1'b1;
          if (lsp1 >= eff_lim) begin
            spilled_r <= 1'b1; cnt_r <= spl_cnt; dir_r <= 1'b1; state_r <= S_RUN;
          end else begin
            state_r <= spilled_r ? S_TRIM : S_DONE;
          end
        end
        S_TRIM: begin
          if (glen_r && 32'(gsize_r) > 32'(glim_r)) begin
            if (32'(rel_r) + 32'(gsize_r) - 32'(glim_r) > 2047) rel_r <= '1;
            else rel_r <= 11'(32'(rel_r) + 32'(gsize_r) - 32'(glim_r));
            gsize_r <= GS_W'(glim_r);
          end
          st_r <= tlfhp_pkg::ST_SPILLED; state_r <= S_DONE;
        end
        S_DONE: begin
          if (op_r && !spilled_r && hin_r != '0) st_r <= tlfhp_pkg::ST_FREED;
          out_handle_out     <= hout_r;
          out_status         <= st_out;
          out_local_count    <= 8'(lsize_r);
          out_global_count   <= 11'(gsize_r);
          out_released_count <= rel_r;
          out_valid <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // sanity checks
  a_lsize: assert property (@(posedge clk) disable iff (!rst_n)
    32'(lsize_r) <= LOCAL_DEPTH) else $error("local size overflow");
  a_gsize: assert property (@(posedge clk) disable iff (!rst_n)
    32'(gsize_r) <= GLOBAL_DEPTH) else $error("global size overflow");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MOVE_WR |-> run_r != '0) else $error("empty run");
endmodule

### sv/tlfhp_ram.sv
// Single-port-write, one-read memory for one free stack.
// Depends on nothing.
module tlfhp_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
